// File: hdl/matrix_vector_product_assert.svh
// ----------------------------------------------------------------------------
// matrix_vector_product assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_PRODUCT_ASSERT_SVH
`define MATRIX_VECTOR_PRODUCT_ASSERT_SVH

// same-cycle implication
`define MVP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvp assertion failed");

// next-cycle implication
`define MVP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvp assertion failed");

`endif

// File: hdl/mvp_pkg.sv
// ----------------------------------------------------------------------------
// mvp_pkg
// types and constants of the matrix vector product engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvp_pkg;

  localparam int unsigned DEF_MAX_DIM = 64;
  localparam int unsigned ELEM_BITS   = 16;
  localparam int unsigned PROD_W      = 2 * ELEM_BITS;
  localparam int unsigned SUM_W       = 40;
  localparam int unsigned VIDX_W      = 6;
  localparam int unsigned OIDX_W      = 6;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;

  // request types
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_MATRIX = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd2;

  localparam logic [DIM_W-1:0] DEF_NUM_ROWS = 7'd64;
  localparam logic [DIM_W-1:0] DEF_NUM_COLS = 7'd64;

  typedef struct packed {
    logic                        req_type;
    logic [VIDX_W-1:0]           vec_index;
    logic signed [ELEM_BITS-1:0] elem_value;
  } mvp_in_t;

  typedef struct packed {
    logic [OIDX_W-1:0]       out_index;
    logic signed [SUM_W-1:0] out_value;
    logic                    out_last;
  } mvp_out_t;

  typedef struct packed {
    logic              vec_we;
    logic              capture;
    logic              mul_en;
    logic              acc_en;
    logic              transpose;
    logic              first_row;
    logic              emit;
    logic              out_last;
    logic              clear_sum;
    logic [OIDX_W-1:0] out_index;
  } mvp_cmd_t;

endpackage

// File: hdl/matrix_vector_product.sv
// vector load: written to the vector store when accepted, no result, busy stays low
// matrix element: busy through S_MUL and S_ACC, result strobe registered from S_ACC when a sum completes
// a new matrix element is taken only after the last one has left S_ACC, as set by the
//   registered memory read, the product register and the column-sum read-modify-write
// reset: synchronous rst_n clears control, counters, row sum and registers
//   (transpose 0, 64 x 64); memories are not cleared, no clearing pass
// ----------------------------------------------------------------------------
// matrix_vector_product
// fixed-point y = M x or y = M^T x engine over a streamed row-major matrix
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_product #(
  parameter int unsigned MAX_DIM = mvp_pkg::DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mvp_pkg::mvp_in_t              in_data,
  output logic                          out_valid,
  output mvp_pkg::mvp_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvp_pkg::DIM_W-1:0]     cfg_data
);
  import mvp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIM);

  mvp_cmd_t         cmd;
  logic [CNT_W-1:0] vec_wr_addr, vec_rd_addr, col_rd_addr, col_wr_addr;

  mvp_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .vec_wr_addr (vec_wr_addr),
    .vec_rd_addr (vec_rd_addr),
    .col_rd_addr (col_rd_addr),
    .col_wr_addr (col_wr_addr)
  );

  mvp_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .vec_wr_addr (vec_wr_addr),
    .vec_rd_addr (vec_rd_addr),
    .col_rd_addr (col_rd_addr),
    .col_wr_addr (col_wr_addr),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule

// File: hdl/mvp_ctrl.sv
// ----------------------------------------------------------------------------
// mvp_ctrl
// controller: configuration registers, row and column counters, item sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_vector_product_assert.svh"

module mvp_ctrl #(
  parameter int unsigned MAX_DIM = mvp_pkg::DEF_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  mvp_pkg::mvp_in_t                 in_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mvp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvp_pkg::DIM_W-1:0]        cfg_data,
  output mvp_pkg::mvp_cmd_t                cmd,
  output logic [$clog2(MAX_DIM)-1:0]       vec_wr_addr,
  output logic [$clog2(MAX_DIM)-1:0]       vec_rd_addr,
  output logic [$clog2(MAX_DIM)-1:0]       col_rd_addr,
  output logic [$clog2(MAX_DIM)-1:0]       col_wr_addr
);
  import mvp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             transpose_r;
  logic [DIM_W-1:0] num_rows_r, num_cols_r;
  logic [CNT_W-1:0] row_cnt_r, col_cnt_r;
  logic [CNT_W-1:0] r_hold_r, c_hold_r;
  logic             row_end_r, col_end_r;

  logic [CMP_W-1:0] rows_eff, cols_eff;
  logic             row_end, col_end;
  logic             accept, mat_accept, cfg_wr;

  assign busy      = (state_r != S_IDLE);
  // an input transfer in the same cycle goes first
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign accept     = start && !busy;
  assign mat_accept = accept && (in_data.req_type == REQ_MATRIX);
  assign cfg_wr     = cfg_valid && cfg_ready &&
                      ((cfg_index == CFG_TRANSPOSE) || (cfg_index == CFG_NUM_ROWS) ||
                       (cfg_index == CFG_NUM_COLS));

  // clamp dimensions to 1..MAX_DIM
  always_comb begin
    if (num_rows_r == '0) begin
      rows_eff = CMP_W'(1);
    end else if (CMP_W'(num_rows_r) > CMP_W'(MAX_DIM)) begin
      rows_eff = CMP_W'(MAX_DIM);
    end else begin
      rows_eff = CMP_W'(num_rows_r);
    end
    if (num_cols_r == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(num_cols_r) > CMP_W'(MAX_DIM)) begin
      cols_eff = CMP_W'(MAX_DIM);
    end else begin
      cols_eff = CMP_W'(num_cols_r);
    end
  end

  assign col_end = (CMP_W'(col_cnt_r) + CMP_W'(1)) >= cols_eff;
  assign row_end = (CMP_W'(row_cnt_r) + CMP_W'(1)) >= rows_eff;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (mat_accept) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      transpose_r <= 1'b0;
      num_rows_r  <= DEF_NUM_ROWS;
      num_cols_r  <= DEF_NUM_COLS;
      row_cnt_r   <= '0;
      col_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TRANSPOSE: transpose_r <= cfg_data[0];
          CFG_NUM_ROWS:  num_rows_r  <= cfg_data;
          CFG_NUM_COLS:  num_cols_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cfg_wr) begin
        row_cnt_r <= '0;
        col_cnt_r <= '0;
      end else if (mat_accept) begin
        if (col_end) begin
          col_cnt_r <= '0;
          row_cnt_r <= row_end ? '0 : CNT_W'(row_cnt_r + CNT_W'(1));
        end else begin
          col_cnt_r <= CNT_W'(col_cnt_r + CNT_W'(1));
        end
      end
    end
  end

  // position of the item in flight
  always_ff @(posedge clk) begin
    if (mat_accept) begin
      r_hold_r  <= row_cnt_r;
      c_hold_r  <= col_cnt_r;
      row_end_r <= row_end;
      col_end_r <= col_end;
    end
  end

  assign vec_wr_addr = CNT_W'(in_data.vec_index);
  assign vec_rd_addr = transpose_r ? row_cnt_r : col_cnt_r;
  assign col_rd_addr = col_cnt_r;
  assign col_wr_addr = c_hold_r;

  always_comb begin
    cmd           = '0;
    cmd.vec_we    = accept && (in_data.req_type == REQ_LOAD) &&
                    (32'(in_data.vec_index) < MAX_DIM);
    cmd.capture   = mat_accept;
    cmd.mul_en    = (state_r == S_MUL);
    cmd.acc_en    = (state_r == S_ACC);
    cmd.transpose = transpose_r;
    cmd.first_row = (r_hold_r == '0);
    cmd.emit      = transpose_r ? row_end_r : col_end_r;
    cmd.out_last  = transpose_r ? col_end_r : row_end_r;
    cmd.out_index = transpose_r ? OIDX_W'(c_hold_r) : OIDX_W'(r_hold_r);
    cmd.clear_sum = cfg_wr;
  end

  `MVP_ASSERT_NXT(a_accept_to_mul, mat_accept, state_r == S_MUL)
  `MVP_ASSERT_NXT(a_mul_to_acc, state_r == S_MUL, state_r == S_ACC && !cfg_ready)
  `MVP_ASSERT_IMP(a_cnt_range, state_r == S_IDLE,
                  (32'(row_cnt_r) < MAX_DIM) && (32'(col_cnt_r) < MAX_DIM))

endmodule

// File: hdl/mvp_datapath.sv
// ----------------------------------------------------------------------------
// mvp_datapath
// vector and column-sum memories, multiplier, accumulator and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvp_datapath #(
  parameter int unsigned MAX_DIM = mvp_pkg::DEF_MAX_DIM
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mvp_pkg::mvp_in_t           in_data,
  input  mvp_pkg::mvp_cmd_t          cmd,
  input  logic [$clog2(MAX_DIM)-1:0] vec_wr_addr,
  input  logic [$clog2(MAX_DIM)-1:0] vec_rd_addr,
  input  logic [$clog2(MAX_DIM)-1:0] col_rd_addr,
  input  logic [$clog2(MAX_DIM)-1:0] col_wr_addr,
  output logic                       out_valid,
  output mvp_pkg::mvp_out_t          out_data
);
  import mvp_pkg::*;

  logic signed [ELEM_BITS-1:0] vec_mem [MAX_DIM];
  logic [SUM_W-1:0]            col_mem [MAX_DIM];

  logic signed [ELEM_BITS-1:0] vec_rd_r, elem_r;
  logic [SUM_W-1:0]            col_rd_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic [SUM_W-1:0]            row_sum_r, row_sum_nxt;
  logic [SUM_W-1:0]            term, col_new;
  logic                        out_valid_r;
  mvp_out_t                    out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.vec_we) begin
      vec_mem[vec_wr_addr] <= in_data.elem_value;
    end
    if (cmd.capture) begin
      vec_rd_r <= vec_mem[vec_rd_addr];
      col_rd_r <= col_mem[col_rd_addr];
      elem_r   <= in_data.elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= elem_r * vec_rd_r;
    end
  end

  assign term        = SUM_W'(prod_r);
  assign col_new     = cmd.first_row ? term : col_rd_r + term;
  assign row_sum_nxt = row_sum_r + term;

  always_ff @(posedge clk) begin
    if (cmd.acc_en && cmd.transpose) begin
      col_mem[col_wr_addr] <= col_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.acc_en && cmd.emit;
      if (cmd.clear_sum) begin
        row_sum_r <= '0;
      end else if (cmd.acc_en && !cmd.transpose) begin
        row_sum_r <= cmd.emit ? '0 : row_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      out_data_r.out_index <= cmd.out_index;
      out_data_r.out_value <= cmd.transpose ? col_new : row_sum_nxt;
      out_data_r.out_last  <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/matrix_vector_product_checker.sv
// ----------------------------------------------------------------------------
// matrix_vector_product checker
// watches the input, result and register channels of the engine, keeps its
// own copy of the vector store, column sums and pass counters, predicts every
// result element and compares each strobed result with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_product_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  mvp_pkg::mvp_in_t              in_data,
  input  logic                          out_valid,
  input  mvp_pkg::mvp_out_t             out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mvp_pkg::DIM_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            sums_checked,
  output int                            sums_pending
);

  import mvp_pkg::*;

  localparam int unsigned DIM   = DEF_MAX_DIM;
  localparam int unsigned SHOWN = 20;

  logic signed [ELEM_BITS-1:0] vector_mem [DIM];
  logic signed [SUM_W-1:0]     col_acc [DIM];
  logic signed [SUM_W-1:0]     row_acc;
  int unsigned                 row_pos;
  int unsigned                 col_pos;
  logic                        transposed;
  logic [DIM_W-1:0]            rows_reg;
  logic [DIM_W-1:0]            cols_reg;
  mvp_out_t                    expected_sums [$];

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return d;
  endfunction

  function automatic void restart_pass();
    row_acc = '0;
    row_pos = 0;
    col_pos = 0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    case (idx)
      CFG_TRANSPOSE: transposed = data[0];
      CFG_NUM_ROWS:  rows_reg = data;
      CFG_NUM_COLS:  cols_reg = data;
      default:       return;
    endcase
    restart_pass();
  endfunction

  function automatic void predict_element(input mvp_in_t item, output bit has_sum,
                                          output mvp_out_t sum);
    int unsigned              rows;
    int unsigned              cols;
    bit                       row_end;
    bit                       col_end;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  term;
    rows    = eff_dim(rows_reg);
    cols    = eff_dim(cols_reg);
    has_sum = 1'b0;
    sum     = '0;
    if (item.req_type == REQ_LOAD) begin
      vector_mem[item.vec_index] = item.elem_value;
      return;
    end
    col_end = (col_pos + 1 >= cols);
    row_end = (row_pos + 1 >= rows);
    if (!transposed) begin
      prod    = item.elem_value * vector_mem[col_pos];
      term    = prod;
      row_acc = row_acc + term;
      if (col_end) begin
        has_sum           = 1'b1;
        sum.out_index     = OIDX_W'(row_pos);
        sum.out_value     = row_acc;
        sum.out_last      = row_end;
        row_acc           = '0;
      end
    end else begin
      prod = item.elem_value * vector_mem[row_pos];
      term = prod;
      // first row overwrites the column sum
      col_acc[col_pos] = (row_pos == 0) ? term : col_acc[col_pos] + term;
      if (row_end) begin
        has_sum       = 1'b1;
        sum.out_index = OIDX_W'(col_pos);
        sum.out_value = col_acc[col_pos];
        sum.out_last  = col_end;
      end
    end
    if (col_end) begin
      col_pos = 0;
      row_pos = row_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < SHOWN) begin
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    bit       has_sum;
    mvp_out_t sum;
    mvp_out_t want;
    if (!rst_n) begin
      transposed = 1'b0;
      rows_reg   = DEF_NUM_ROWS;
      cols_reg   = DEF_NUM_COLS;
      restart_pass();
      expected_sums.delete();
      fail_count   = 0;
      sums_checked = 0;
      sums_pending <= 0;
    end else begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid unknown", 0, 0);
      end else if (out_valid) begin
        if (expected_sums.size() == 0) begin
          report_mismatch("result with nothing expected, out_index", out_data.out_index, 0);
        end else begin
          want = expected_sums.pop_front();
          sums_checked++;
          if (out_data.out_index !== want.out_index) begin
            report_mismatch("out_index", out_data.out_index, want.out_index);
          end
          if (out_data.out_value !== want.out_value) begin
            report_mismatch("out_value", out_data.out_value, want.out_value);
          end
          if (out_data.out_last !== want.out_last) begin
            report_mismatch("out_last", out_data.out_last, want.out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
      end
      if (start && !busy) begin
        predict_element(in_data, has_sum, sum);
        if (has_sum) expected_sums.push_back(sum);
      end
      sums_pending <= expected_sums.size();
    end
  end

endmodule

// File: tb/matrix_vector_product_test.sv
// ----------------------------------------------------------------------------
// matrix_vector_product test
// loads the vector store, then streams row-major matrices through both modes
// under changing dimensions, including dimensions of zero and above the
// maximum and restarts in mid pass; a checker beside the engine predicts and
// compares every result element
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix_vector_product_test;

  import mvp_pkg::*;

  localparam int unsigned DIM          = DEF_MAX_DIM;
  localparam int unsigned ITEM_TARGET  = 1050;
  localparam int unsigned QUIET_ITEMS  = 900;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PASS_CAP     = 128;
  localparam int unsigned LOAD_PCT     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [3:0] SET_MODE   = 4'b0001;
  localparam logic [3:0] SET_ROWS   = 4'b0010;
  localparam logic [3:0] SET_COLS   = 4'b0100;
  localparam logic [3:0] SET_UNUSED = 4'b1000;
  localparam logic [3:0] SET_DIMS   = SET_MODE | SET_ROWS | SET_COLS;

  localparam logic [ELEM_BITS-1:0] ELEM_MIN = 16'h8000;
  localparam logic [ELEM_BITS-1:0] ELEM_MAX = 16'h7fff;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  mvp_in_t              in_data;
  logic                 out_valid;
  mvp_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  int                   fail_count;
  int                   sums_checked;
  int                   sums_pending;

  int unsigned          cycle_count   = 0;
  int unsigned          items_sent    = 0;
  int unsigned          elements_sent = 0;
  int unsigned          loads_sent    = 0;
  int unsigned          reg_writes    = 0;
  int unsigned          settings_used = 0;
  bit                   idle_on       = 1'b1;
  logic [DIM_W-1:0]     rows_now      = DEF_NUM_ROWS;
  logic [DIM_W-1:0]     cols_now      = DEF_NUM_COLS;

  matrix_vector_product i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  matrix_vector_product_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .sums_checked (sums_checked),
    .sums_pending (sums_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sums_pending);
      $display("matrix_vector_product: mismatch");
      $finish;
    end
  end

  function automatic int unsigned dim_used(logic [DIM_W-1:0] d);
    return (d == 0) ? 1 : ((d > DIM) ? DIM : d);
  endfunction

  function automatic logic [ELEM_BITS-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return '0;
      3:       return '1;
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_small();
    return ($urandom_range(0, 9) == 0) ? '0 : DIM_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [DIM_W-1:0] pick_big();
    return ($urandom_range(0, 2) == 0) ? DIM_W'($urandom_range(DIM + 1, 127))
                                       : DIM_W'($urandom_range(DIM / 2 + 1, DIM));
  endfunction

  task automatic send_item(input logic req, input logic [VIDX_W-1:0] idx,
                           input logic [ELEM_BITS-1:0] value);
    mvp_in_t item;
    item.req_type   = req;
    item.vec_index  = idx;
    item.elem_value = value;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    items_sent++;
    if (req == REQ_MATRIX) elements_sent++;
    else loads_sent++;
  endtask

  task automatic stream_elements(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < LOAD_PCT) begin
        send_item(REQ_LOAD, VIDX_W'($urandom_range(0, DIM - 1)), pick_value());
      end
      send_item(REQ_MATRIX, VIDX_W'($urandom), pick_value());
    end
  endtask

  // engine idle: no transfer in flight and every result delivered
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (busy || sums_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic apply_setting(input logic [3:0] mask, input logic mode,
                               input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    settle();
    if (mask & SET_MODE) write_reg(CFG_TRANSPOSE, DIM_W'(mode));
    if (mask & SET_ROWS) begin
      write_reg(CFG_NUM_ROWS, rows);
      rows_now = rows;
    end
    if (mask & SET_COLS) begin
      write_reg(CFG_NUM_COLS, cols);
      cols_now = cols;
    end
    if (mask & SET_UNUSED) write_reg(CFG_UNUSED, DIM_W'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned      order [DIM];
    int unsigned      k;
    int unsigned      j;
    int unsigned      tmp;
    int unsigned      kind;
    int unsigned      total;
    logic [3:0]       mask;
    logic [DIM_W-1:0] rows_pick;
    logic [DIM_W-1:0] cols_pick;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both modes, clamped dimensions, restart in mid pass
    send_item(REQ_LOAD, '0, ELEM_MIN);
    send_item(REQ_LOAD, 6'd1, ELEM_MAX);
    send_item(REQ_LOAD, 6'd2, '1);
    send_item(REQ_LOAD, '1, ELEM_MAX);

    apply_setting(SET_DIMS, 1'b0, 7'd2, 7'd2);
    send_item(REQ_MATRIX, '0, ELEM_MIN);
    send_item(REQ_MATRIX, '1, ELEM_MIN);
    send_item(REQ_MATRIX, '0, ELEM_MAX);
    send_item(REQ_MATRIX, '1, ELEM_MAX);

    apply_setting(SET_MODE, 1'b1, rows_now, cols_now);
    send_item(REQ_MATRIX, '0, ELEM_MIN);
    send_item(REQ_MATRIX, '0, ELEM_MAX);
    send_item(REQ_MATRIX, '1, ELEM_MIN);
    send_item(REQ_MATRIX, '1, '1);

    send_item(REQ_MATRIX, '0, ELEM_MAX);
    apply_setting(SET_COLS, 1'b1, rows_now, '0);
    send_item(REQ_MATRIX, '0, ELEM_MIN);
    send_item(REQ_MATRIX, '1, ELEM_MIN);

    apply_setting(SET_DIMS, 1'b0, '0, 7'd3);
    send_item(REQ_MATRIX, '0, ELEM_MIN);
    send_item(REQ_MATRIX, '0, ELEM_MAX);
    send_item(REQ_MATRIX, '0, '0);

    apply_setting(SET_MODE, 1'b1, rows_now, cols_now);
    send_item(REQ_MATRIX, '1, ELEM_MAX);
    send_item(REQ_MATRIX, '1, ELEM_MIN);
    send_item(REQ_MATRIX, '1, '1);

    apply_setting(SET_DIMS | SET_UNUSED, 1'b0, '1, 7'd1);
    send_item(REQ_MATRIX, '0, ELEM_MIN);
    send_item(REQ_MATRIX, '0, ELEM_MAX);
    send_item(REQ_MATRIX, '0, ELEM_MIN);

    // random: fill the whole vector store in shuffled order
    for (k = 0; k < DIM; k++) order[k] = k;
    for (k = DIM - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < DIM; k++) send_item(REQ_LOAD, VIDX_W'(order[k]), pick_value());

    while (items_sent < ITEM_TARGET) begin
      idle_on = (items_sent < QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 11);
      if (kind == 0) begin
        rows_pick = pick_big();
        cols_pick = DIM_W'($urandom_range(0, 2));
      end else if (kind == 1) begin
        rows_pick = DIM_W'($urandom_range(0, 2));
        cols_pick = pick_big();
      end else begin
        rows_pick = pick_small();
        cols_pick = pick_small();
      end
      mask = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : SET_DIMS;
      if (kind < 2) mask = mask | SET_DIMS;
      apply_setting(mask, 1'($urandom), rows_pick, cols_pick);

      total = dim_used(rows_now) * dim_used(cols_now);
      if (total > PASS_CAP) begin
        total = $urandom_range(1, DIM);
      end else begin
        total = total * $urandom_range(1, 2);
        // broken pass: stop short or run into the next pass
        case ($urandom_range(0, 5))
          0:       total = $urandom_range(1, total);
          1:       total = total + $urandom_range(1, 5);
          default: ;
        endcase
      end
      if (total > ITEM_TARGET - items_sent) total = ITEM_TARGET - items_sent;
      stream_elements(total);
    end

    settle();
    $display("covered %0d items: %0d matrix elements and %0d vector loads", items_sent,
             elements_sent, loads_sent);
    $display("%0d register writes over %0d settings, %0d result elements compared",
             reg_writes, settings_used, sums_checked);
    if (fail_count == 0 && sums_pending == 0) begin
      $display("matrix_vector_product: match");
    end else begin
      $display("matrix_vector_product: mismatch");
    end
    $finish;
  end

endmodule
